/* sv/mvpi_pkg.sv */
package mvpi_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int QUERY_BITS     = 16;
	localparam int TOL_BITS       = 32;
	localparam int SUM_BITS       = 63;
	localparam int CFG_DATA_BITS  = 32;
	localparam int CFG_INDEX_BITS = 2;

	// A queued triangle holds twelve differences of COORD_BITS+1 bits and the last flag.
	localparam int ENTRY_FIELDS = 12;
	localparam int SLOT_U       = 0;
	localparam int SLOT_W       = 3;
	localparam int SLOT_DR      = 6;
	localparam int SLOT_DQ      = 9;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_QUERY_X   = 2'd0,
		REG_QUERY_Y   = 2'd1,
		REG_QUERY_Z   = 2'd2,
		REG_TOLERANCE = 2'd3
	} cfg_reg_t;

	function automatic int entry_bits(int coord_bits);
		return ENTRY_FIELDS * (coord_bits + 1) + 1;
	endfunction

endpackage

/* sv/mvpi_front.sv */
module mvpi_front #(
	parameter int COORD_BITS = mvpi_pkg::COORD_BITS_DEF,
	localparam int D  = COORD_BITS + 1,
	localparam int EB = mvpi_pkg::entry_bits(COORD_BITS)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         take,
	input  logic signed [COORD_BITS-1:0] a_x,
	input  logic signed [COORD_BITS-1:0] a_y,
	input  logic signed [COORD_BITS-1:0] a_z,
	input  logic signed [COORD_BITS-1:0] b_x,
	input  logic signed [COORD_BITS-1:0] b_y,
	input  logic signed [COORD_BITS-1:0] b_z,
	input  logic signed [COORD_BITS-1:0] c_x,
	input  logic signed [COORD_BITS-1:0] c_y,
	input  logic signed [COORD_BITS-1:0] c_z,
	input  logic                         last_triangle,
	input  logic signed [COORD_BITS-1:0] qx,
	input  logic signed [COORD_BITS-1:0] qy,
	input  logic signed [COORD_BITS-1:0] qz,
	output logic [EB-1:0]                entry
);

	logic signed [COORD_BITS-1:0] refpt_q [3];
	logic                         first_q;

	logic signed [D-1:0] ea [3];
	logic signed [D-1:0] eb [3];
	logic signed [D-1:0] ec [3];
	logic signed [D-1:0] eq [3];
	logic signed [D-1:0] er [3];

	always_comb begin
		ea[0] = D'(a_x);
		ea[1] = D'(a_y);
		ea[2] = D'(a_z);
		eb[0] = D'(b_x);
		eb[1] = D'(b_y);
		eb[2] = D'(b_z);
		ec[0] = D'(c_x);
		ec[1] = D'(c_y);
		ec[2] = D'(c_z);
		eq[0] = D'(qx);
		eq[1] = D'(qy);
		eq[2] = D'(qz);
		for (int k = 0; k < 3; k++) begin
			// The first triangle of a mesh is its own reference, so its reference term is zero.
			er[k] = first_q ? ea[k] : D'(refpt_q[k]);
		end
	end

	always_comb begin
		entry = '0;
		for (int k = 0; k < 3; k++) begin
			entry[(mvpi_pkg::SLOT_U + k) * D +: D]  = eb[k] - ea[k];
			entry[(mvpi_pkg::SLOT_W + k) * D +: D]  = ec[k] - ea[k];
			entry[(mvpi_pkg::SLOT_DR + k) * D +: D] = er[k] - ea[k];
			entry[(mvpi_pkg::SLOT_DQ + k) * D +: D] = eq[k] - ea[k];
		end
		entry[EB-1] = last_triangle;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
			for (int k = 0; k < 3; k++) begin
				refpt_q[k] <= '0;
			end
		end else if (take) begin
			first_q <= last_triangle;
			if (first_q) begin
				refpt_q[0] <= a_x;
				refpt_q[1] <= a_y;
				refpt_q[2] <= a_z;
			end
		end
	end

endmodule

/* sv/mvpi_queue.sv */
module mvpi_queue #(
	parameter int DATA_BITS = mvpi_pkg::entry_bits(mvpi_pkg::COORD_BITS_DEF)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr,
	input  logic [DATA_BITS-1:0] wdata,
	output logic                 full,
	input  logic                 rd,
	output logic [DATA_BITS-1:0] rdata,
	output logic                 nempty
);

	logic [DATA_BITS-1:0] slot_q [2];
	logic                 wptr_q;
	logic                 rptr_q;
	logic [1:0]           count_q;

	assign full   = count_q[1];
	assign nempty = (count_q != 2'd0);
	assign rdata  = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (wr) begin
				wptr_q <= ~wptr_q;
			end
			if (rd) begin
				rptr_q <= ~rptr_q;
			end
			if (wr && !rd) begin
				count_q <= count_q + 2'd1;
			end else if (rd && !wr) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

/* sv/mvpi_back.sv */
module mvpi_back #(
	parameter int COORD_BITS = mvpi_pkg::COORD_BITS_DEF,
	localparam int D  = COORD_BITS + 1,
	localparam int EB = mvpi_pkg::entry_bits(COORD_BITS),
	localparam int SB = mvpi_pkg::SUM_BITS,
	localparam int TB = mvpi_pkg::TOL_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  logic [EB-1:0] head,
	output logic          head_pop,
	input  logic [TB-1:0] tolerance,
	input  logic          pop,
	output logic          empty,
	output logic [SB-1:0] reference_six_volume,
	output logic [SB-1:0] query_six_volume,
	output logic          inside_res,
	output logic          overflowed
);

	localparam int N         = 2 * COORD_BITS + 3;
	localparam int P         = N + D;
	localparam int T         = 3 * COORD_BITS + 6;
	localparam int STEP_BITS = 4;
	localparam logic [STEP_BITS-1:0] STEP_DOT  = STEP_BITS'(6);
	localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(11);
	localparam logic [SB-1:0] SUM_MAX = {SB{1'b1}};
	// Operand order of the six cross-product terms: n0 = u1*w2 - u2*w1 and so on.
	localparam logic [1:0] CROSS_A [6] = '{2'd1, 2'd2, 2'd2, 2'd0, 2'd0, 2'd1};
	localparam logic [1:0] CROSS_B [6] = '{2'd2, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0};

	logic signed [D-1:0] u [3];
	logic signed [D-1:0] w [3];
	logic signed [D-1:0] dr [3];
	logic signed [D-1:0] dq [3];

	logic [STEP_BITS-1:0] step_q;
	logic [STEP_BITS-1:0] dot_off;
	logic [1:0]           dot_k;
	logic                 start_ok;
	logic                 active;

	logic signed [N-1:0]  mul_a;
	logic signed [D-1:0]  mul_b;
	logic signed [P-1:0]  prod_c;

	logic                 acc_v_s2;
	logic [STEP_BITS-1:0] acc_step_s2;
	logic                 acc_last_s2;
	logic signed [P-1:0]  prod_s2;
	logic [STEP_BITS-1:0] acc_off;
	logic [1:0]           acc_k;

	logic signed [N-1:0]  n_q [3];
	logic signed [T-1:0]  tr_q;
	logic signed [T-1:0]  tq_q;

	logic                 tail_v_s3;
	logic                 tail_last_s3;
	logic [T-1:0]         mag_r;
	logic [T-1:0]         mag_q;

	logic                 abs_v_s4;
	logic                 abs_last_s4;
	logic [SB-1:0]        absr_s4;
	logic [SB-1:0]        absq_s4;

	logic [SB-1:0]        ref_sum_q;
	logic [SB-1:0]        qry_sum_q;
	logic                 sat_flag_q;
	logic [SB:0]          add_r;
	logic [SB:0]          add_q;
	logic                 sat_r;
	logic                 sat_q;
	logic [SB-1:0]        new_r;
	logic [SB-1:0]        new_q;

	logic                 fin_v_q;
	logic [SB-1:0]        fin_ref_q;
	logic [SB-1:0]        fin_qry_q;
	logic                 fin_ovf_q;
	logic                 load;
	logic [SB-1:0]        excess;

	logic                 out_v_q;
	logic [SB-1:0]        out_ref_q;
	logic [SB-1:0]        out_qry_q;
	logic                 out_inside_q;
	logic                 out_ovf_q;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			u[k]  = head[(mvpi_pkg::SLOT_U + k) * D +: D];
			w[k]  = head[(mvpi_pkg::SLOT_W + k) * D +: D];
			dr[k] = head[(mvpi_pkg::SLOT_DR + k) * D +: D];
			dq[k] = head[(mvpi_pkg::SLOT_DQ + k) * D +: D];
		end
	end

	// A new triangle may only start when no finished mesh can still be waiting
	// for the finishing register by the time this triangle reaches it.
	assign start_ok = !(fin_v_q || (acc_v_s2 && acc_last_s2) || (tail_v_s3 && tail_last_s3)
		|| (abs_v_s4 && abs_last_s4));
	assign active   = head_valid && ((step_q != '0) || start_ok);
	assign head_pop = active && (step_q == STEP_LAST);

	assign dot_off = step_q - STEP_DOT;
	assign dot_k   = dot_off[2:1];

	always_comb begin
		if (step_q < STEP_DOT) begin
			mul_a = N'(u[CROSS_A[step_q[2:0]]]);
			mul_b = w[CROSS_B[step_q[2:0]]];
		end else begin
			mul_a = n_q[dot_k];
			mul_b = dot_off[0] ? dq[dot_k] : dr[dot_k];
		end
	end

	assign prod_c = mul_a * mul_b;

	always_ff @(posedge clk) begin
		prod_s2     <= prod_c;
		acc_step_s2 <= step_q;
		acc_last_s2 <= head[EB-1];
	end

	assign acc_off = acc_step_s2 - STEP_DOT;
	assign acc_k   = acc_step_s2[2:1];

	always_ff @(posedge clk) begin
		if (acc_v_s2) begin
			if (acc_step_s2 < STEP_DOT) begin
				if (!acc_step_s2[0]) begin
					n_q[acc_k] <= N'(prod_s2);
				end else begin
					n_q[acc_k] <= n_q[acc_k] - N'(prod_s2);
				end
			end else if (acc_off[0]) begin
				tq_q <= (acc_off < STEP_BITS'(2)) ? T'(prod_s2) : tq_q + T'(prod_s2);
			end else begin
				tr_q <= (acc_off < STEP_BITS'(2)) ? T'(prod_s2) : tr_q + T'(prod_s2);
			end
		end
	end

	assign mag_r = tr_q[T-1] ? T'(-tr_q) : T'(tr_q);
	assign mag_q = tq_q[T-1] ? T'(-tq_q) : T'(tq_q);

	always_ff @(posedge clk) begin
		tail_last_s3 <= acc_last_s2;
		abs_last_s4  <= tail_last_s3;
		absr_s4      <= SB'(mag_r);
		absq_s4      <= SB'(mag_q);
	end

	assign add_r = {1'b0, ref_sum_q} + {1'b0, absr_s4};
	assign add_q = {1'b0, qry_sum_q} + {1'b0, absq_s4};
	assign sat_r = add_r[SB];
	assign sat_q = add_q[SB];
	assign new_r = sat_r ? SUM_MAX : add_r[SB-1:0];
	assign new_q = sat_q ? SUM_MAX : add_q[SB-1:0];

	always_ff @(posedge clk) begin
		if (abs_v_s4 && abs_last_s4) begin
			fin_ref_q <= new_r;
			fin_qry_q <= new_q;
			fin_ovf_q <= sat_flag_q | sat_r | sat_q;
		end
	end

	assign load   = fin_v_q && (!out_v_q || pop);
	assign excess = fin_qry_q - fin_ref_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_ref_q    <= fin_ref_q;
			out_qry_q    <= fin_qry_q;
			out_ovf_q    <= fin_ovf_q;
			out_inside_q <= (fin_qry_q <= fin_ref_q) || (excess <= SB'(tolerance));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= '0;
			acc_v_s2   <= 1'b0;
			tail_v_s3  <= 1'b0;
			abs_v_s4   <= 1'b0;
			ref_sum_q  <= '0;
			qry_sum_q  <= '0;
			sat_flag_q <= 1'b0;
			fin_v_q    <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			if (active) begin
				step_q <= (step_q == STEP_LAST) ? '0 : step_q + STEP_BITS'(1);
			end
			acc_v_s2  <= active;
			tail_v_s3 <= acc_v_s2 && (acc_step_s2 == STEP_LAST);
			abs_v_s4  <= tail_v_s3;

			if (abs_v_s4) begin
				if (abs_last_s4) begin
					ref_sum_q  <= '0;
					qry_sum_q  <= '0;
					sat_flag_q <= 1'b0;
				end else begin
					ref_sum_q  <= new_r;
					qry_sum_q  <= new_q;
					sat_flag_q <= sat_flag_q | sat_r | sat_q;
				end
			end

			if (abs_v_s4 && abs_last_s4) begin
				fin_v_q <= 1'b1;
			end else if (load) begin
				fin_v_q <= 1'b0;
			end

			if (load) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign empty                = !out_v_q;
	assign reference_six_volume = out_ref_q;
	assign query_six_volume     = out_qry_q;
	assign inside_res           = out_inside_q;
	assign overflowed           = out_ovf_q;

endmodule

/* sv/mesh_volume_point_inside.sv */
// Channel   Direction  Handshake        Transfer when        Payload
// triangle  in         push / full      push && !full        a_x..c_z, last_triangle
// result    out        empty / pop      pop && !empty        six-volumes, inside_res, overflowed
// config    in         cfg_write        cfg_write            cfg_index, cfg_data
//
// In the back end one shared multiplier forms the six cross-product terms and six
// triple-product terms of each triangle, one a cycle.
// A result passes from the sums through the finishing register to the output register;
// a new mesh does not start while a finished mesh is bound for or held in the finishing register.
// Reset is asynchronous and clears the sums, the reference capture, the queue and the registers.
// A two-entry queue separates the front from the back end, so full rises only when it holds
// two triangles; a waiting result blocks nothing until a second finished mesh stands behind it.
module mesh_volume_point_inside #(
	parameter int COORD_BITS = mvpi_pkg::COORD_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   push,
	output logic                                   full,
	input  logic signed [COORD_BITS-1:0]           a_x,
	input  logic signed [COORD_BITS-1:0]           a_y,
	input  logic signed [COORD_BITS-1:0]           a_z,
	input  logic signed [COORD_BITS-1:0]           b_x,
	input  logic signed [COORD_BITS-1:0]           b_y,
	input  logic signed [COORD_BITS-1:0]           b_z,
	input  logic signed [COORD_BITS-1:0]           c_x,
	input  logic signed [COORD_BITS-1:0]           c_y,
	input  logic signed [COORD_BITS-1:0]           c_z,
	input  logic                                   last_triangle,
	output logic                                   empty,
	input  logic                                   pop,
	output logic [mvpi_pkg::SUM_BITS-1:0]          reference_six_volume,
	output logic [mvpi_pkg::SUM_BITS-1:0]          query_six_volume,
	output logic                                   inside_res,
	output logic                                   overflowed,
	input  logic                                   cfg_write,
	input  logic [mvpi_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [mvpi_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

	localparam int EB = mvpi_pkg::entry_bits(COORD_BITS);
	localparam int QB = mvpi_pkg::QUERY_BITS;
	localparam int TB = mvpi_pkg::TOL_BITS;
	localparam int QW = (COORD_BITS > QB) ? COORD_BITS : QB;

	logic [QB-1:0] query_x_q;
	logic [QB-1:0] query_y_q;
	logic [QB-1:0] query_z_q;
	logic [TB-1:0] tol_q;

	logic [QW-1:0] qx_ext;
	logic [QW-1:0] qy_ext;
	logic [QW-1:0] qz_ext;

	logic          take;
	logic [EB-1:0] entry;
	logic          q_full;
	logic          q_rd;
	logic [EB-1:0] q_head;
	logic          q_nempty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_x_q <= '0;
			query_y_q <= '0;
			query_z_q <= '0;
			tol_q     <= '0;
		end else if (cfg_write) begin
			unique case (mvpi_pkg::cfg_reg_t'(cfg_index))
				mvpi_pkg::REG_QUERY_X:   query_x_q <= cfg_data[QB-1:0];
				mvpi_pkg::REG_QUERY_Y:   query_y_q <= cfg_data[QB-1:0];
				mvpi_pkg::REG_QUERY_Z:   query_z_q <= cfg_data[QB-1:0];
				mvpi_pkg::REG_TOLERANCE: tol_q     <= cfg_data[TB-1:0];
				default: ;
			endcase
		end
	end

	// The query registers keep sixteen bits; the coordinate is their low COORD_BITS bits.
	assign qx_ext = QW'(query_x_q);
	assign qy_ext = QW'(query_y_q);
	assign qz_ext = QW'(query_z_q);

	assign full = q_full;
	assign take = push && !q_full;

	mvpi_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.a_x           (a_x),
		.a_y           (a_y),
		.a_z           (a_z),
		.b_x           (b_x),
		.b_y           (b_y),
		.b_z           (b_z),
		.c_x           (c_x),
		.c_y           (c_y),
		.c_z           (c_z),
		.last_triangle (last_triangle),
		.qx            (qx_ext[COORD_BITS-1:0]),
		.qy            (qy_ext[COORD_BITS-1:0]),
		.qz            (qz_ext[COORD_BITS-1:0]),
		.entry         (entry)
	);

	mvpi_queue #(
		.DATA_BITS(EB)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (take),
		.wdata  (entry),
		.full   (q_full),
		.rd     (q_rd),
		.rdata  (q_head),
		.nempty (q_nempty)
	);

	mvpi_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk                  (clk),
		.arst_n               (arst_n),
		.head_valid           (q_nempty),
		.head                 (q_head),
		.head_pop             (q_rd),
		.tolerance            (tol_q),
		.pop                  (pop),
		.empty                (empty),
		.reference_six_volume (reference_six_volume),
		.query_six_volume     (query_six_volume),
		.inside_res           (inside_res),
		.overflowed           (overflowed)
	);

	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |-> q_nempty)
		else $error("back end removed a triangle from an empty queue");

	a_inside_when_not_above: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (query_six_volume <= reference_six_volume)) |-> inside_res)
		else $error("inside_res low although the query volume is not above the reference");

	a_tolerance_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_write && (cfg_index == mvpi_pkg::REG_TOLERANCE)) |=>
		(tol_q == $past(cfg_data[TB-1:0])))
		else $error("tolerance register did not take the written value");

endmodule

/* test/testbench.sv */
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          CB             = mvpi_pkg::COORD_BITS_DEF;
	localparam int          DRAIN_CYCLES   = 48;
	localparam int          LONG_TRIANGLES = 100;
	localparam int          PHASE_ITEMS    = 225;
	localparam logic [63:0] SUM_MAX        = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef logic signed [CB-1:0]          coord_t;
	typedef logic [mvpi_pkg::SUM_BITS-1:0] sum_t;

	localparam coord_t COORD_MIN = coord_t'(-(2 ** (CB - 1)));
	localparam coord_t COORD_MAX = coord_t'(2 ** (CB - 1) - 1);

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} vertex_t;

	typedef struct packed {
		vertex_t a;
		vertex_t b;
		vertex_t c;
		logic    last;
	} triangle_t;

	typedef struct packed {
		sum_t reference_six_volume;
		sum_t query_six_volume;
		logic inside_res;
		logic overflowed;
	} volume_result_t;

	// Tracks both six-volume sums of the mesh in flight and queues the result of each
	// finished mesh until the block hands it over.
	class volume_scoreboard;
		coord_t         query [3];
		logic [31:0]    tolerance;
		longint         anchor [3];
		bit             awaiting_first;
		logic [63:0]    reference_sum;
		logic [63:0]    query_sum;
		bit             saturated;
		volume_result_t expected_volumes [$];
		int             errors;
		int             triangles;
		int             meshes;
		int             checked;
		int             saturated_meshes;
		int             inside_meshes;

		function new();
			foreach (query[i]) begin
				query[i]  = '0;
				anchor[i] = 0;
			end
			tolerance      = '0;
			awaiting_first = 1'b1;
			reference_sum  = '0;
			query_sum      = '0;
			saturated      = 1'b0;
		endfunction

		function void set_register(mvpi_pkg::cfg_reg_t idx, logic [31:0] data);
			case (idx)
				mvpi_pkg::REG_QUERY_X:   query[0] = coord_t'(data);
				mvpi_pkg::REG_QUERY_Y:   query[1] = coord_t'(data);
				mvpi_pkg::REG_QUERY_Z:   query[2] = coord_t'(data);
				mvpi_pkg::REG_TOLERANCE: tolerance = data;
				default: ;
			endcase
		endfunction

		function longint coord_at(vertex_t v, int i);
			case (i)
				0:       return longint'($signed(v.x));
				1:       return longint'($signed(v.y));
				default: return longint'($signed(v.z));
			endcase
		endfunction

		function logic [63:0] abs_triple(longint n [3], longint a [3], longint p [3]);
			longint t;
			t = n[0] * (p[0] - a[0]) + n[1] * (p[1] - a[1]) + n[2] * (p[2] - a[2]);
			return (t < 0) ? 64'(-t) : 64'(t);
		endfunction

		function logic [63:0] accumulate(logic [63:0] s, logic [63:0] x);
			if (x > SUM_MAX - s) begin
				saturated = 1'b1;
				return SUM_MAX;
			end
			return s + x;
		endfunction

		function void note_triangle(triangle_t t);
			longint         a [3];
			longint         b [3];
			longint         c [3];
			longint         u [3];
			longint         w [3];
			longint         n [3];
			longint         q [3];
			volume_result_t r;
			for (int i = 0; i < 3; i++) begin
				a[i] = coord_at(t.a, i);
				b[i] = coord_at(t.b, i);
				c[i] = coord_at(t.c, i);
				u[i] = b[i] - a[i];
				w[i] = c[i] - a[i];
				q[i] = longint'($signed(query[i]));
			end
			n[0] = u[1] * w[2] - u[2] * w[1];
			n[1] = u[2] * w[0] - u[0] * w[2];
			n[2] = u[0] * w[1] - u[1] * w[0];
			// The first triangle of a mesh supplies the reference point, so its own
			// reference term is always zero.
			if (awaiting_first) begin
				anchor         = a;
				awaiting_first = 1'b0;
			end
			reference_sum = accumulate(reference_sum, abs_triple(n, a, anchor));
			query_sum     = accumulate(query_sum, abs_triple(n, a, q));
			triangles++;
			if (!t.last)
				return;
			r.reference_six_volume = reference_sum[mvpi_pkg::SUM_BITS-1:0];
			r.query_six_volume     = query_sum[mvpi_pkg::SUM_BITS-1:0];
			r.inside_res           = (query_sum <= reference_sum) ||
			                         (query_sum - reference_sum <= 64'(tolerance));
			r.overflowed           = saturated;
			expected_volumes.push_back(r);
			meshes++;
			saturated_meshes += r.overflowed;
			inside_meshes    += r.inside_res;
			reference_sum  = '0;
			query_sum      = '0;
			saturated      = 1'b0;
			awaiting_first = 1'b1;
		endfunction

		function void check_result(volume_result_t got);
			volume_result_t e;
			if (expected_volumes.size() == 0) begin
				$error("result with no finished mesh pending: reference_six_volume %0d, %s %0d",
				       got.reference_six_volume, "query_six_volume", got.query_six_volume);
				errors++;
				return;
			end
			e = expected_volumes.pop_front();
			checked++;
			if (got.reference_six_volume !== e.reference_six_volume) begin
				$error("reference_six_volume: expected %0d, actual %0d",
				       e.reference_six_volume, got.reference_six_volume);
				errors++;
			end
			if (got.query_six_volume !== e.query_six_volume) begin
				$error("query_six_volume: expected %0d, actual %0d",
				       e.query_six_volume, got.query_six_volume);
				errors++;
			end
			if (got.inside_res !== e.inside_res) begin
				$error("inside_res: expected %0b, actual %0b", e.inside_res, got.inside_res);
				errors++;
			end
			if (got.overflowed !== e.overflowed) begin
				$error("overflowed: expected %0b, actual %0b", e.overflowed, got.overflowed);
				errors++;
			end
		endfunction
	endclass

	logic                                clk = 1'b0;
	logic                                arst_n;
	logic                                push;
	logic                                full;
	coord_t                              a_x, a_y, a_z;
	coord_t                              b_x, b_y, b_z;
	coord_t                              c_x, c_y, c_z;
	logic                                last_triangle;
	logic                                empty;
	logic                                pop;
	sum_t                                reference_six_volume;
	sum_t                                query_six_volume;
	logic                                inside_res;
	logic                                overflowed;
	logic                                cfg_write;
	logic [mvpi_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	logic [mvpi_pkg::CFG_DATA_BITS-1:0]  cfg_data;

	volume_scoreboard tracker;
	triangle_t        mesh_queue [$];
	vertex_t          query_point;
	bit               idling;

	mesh_volume_point_inside i_dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic coord_t extreme_coord();
		case ($urandom_range(0, 4))
			0:       return COORD_MIN;
			1:       return COORD_MAX;
			2:       return coord_t'(0);
			3:       return coord_t'(-1);
			default: return coord_t'(1);
		endcase
	endfunction

	function automatic vertex_t near_vertex(vertex_t centre, int span);
		vertex_t v;
		v.x = coord_t'(int'($signed(centre.x)) + int'($urandom_range(0, 2 * span)) - span);
		v.y = coord_t'(int'($signed(centre.y)) + int'($urandom_range(0, 2 * span)) - span);
		v.z = coord_t'(int'($signed(centre.z)) + int'($urandom_range(0, 2 * span)) - span);
		return v;
	endfunction

	function automatic vertex_t any_vertex();
		vertex_t v;
		case ($urandom_range(0, 7))
			6: begin
				v.x = extreme_coord();
				v.y = extreme_coord();
				v.z = extreme_coord();
			end
			7:       v = near_vertex('0, 512);
			default: begin
				v.x = coord_t'($urandom);
				v.y = coord_t'($urandom);
				v.z = coord_t'($urandom);
			end
		endcase
		return v;
	endfunction

	function automatic void add_face(vertex_t a, vertex_t b, vertex_t c);
		triangle_t t;
		t.a    = a;
		t.b    = b;
		t.c    = c;
		t.last = 1'b0;
		mesh_queue.push_back(t);
	endfunction

	function automatic void add_tetra(vertex_t v0, vertex_t v1, vertex_t v2, vertex_t v3);
		add_face(v0, v1, v2);
		add_face(v0, v3, v1);
		add_face(v0, v2, v3);
		add_face(v1, v3, v2);
	endfunction

	function automatic void close_mesh();
		triangle_t t;
		t      = mesh_queue.pop_back();
		t.last = 1'b1;
		mesh_queue.push_back(t);
	endfunction

	function automatic void build_random_mesh();
		vertex_t v [4];
		vertex_t a, b, c;
		int      span;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				// Closed tetrahedra around the query point; a fifth are cut short.
				case ($urandom_range(0, 2))
					0:       span = 300;
					1:       span = 5000;
					default: span = 40000;
				endcase
				foreach (v[i])
					v[i] = near_vertex(query_point, span);
				add_tetra(v[0], v[1], v[2], v[3]);
				if ($urandom_range(0, 4) == 0)
					repeat ($urandom_range(1, 3)) void'(mesh_queue.pop_back());
			end
			5, 6, 7: begin
				repeat ($urandom_range(1, 10)) begin
					a = any_vertex();
					b = any_vertex();
					c = any_vertex();
					case ($urandom_range(0, 11))
						0:       b = a;
						1:       c = a;
						2:       c = b;
						default: ;
					endcase
					add_face(a, b, c);
				end
			end
			8: begin
				repeat ($urandom_range(20, 60))
					add_face(any_vertex(), any_vertex(), any_vertex());
			end
			default: begin
				a.x = extreme_coord(); a.y = extreme_coord(); a.z = extreme_coord();
				b.x = extreme_coord(); b.y = extreme_coord(); b.z = extreme_coord();
				c.x = extreme_coord(); c.y = extreme_coord(); c.z = extreme_coord();
				add_face(a, b, c);
			end
		endcase
		close_mesh();
	endfunction

	function automatic int producer_gap();
		if (idling && $urandom_range(0, 9) == 0)
			return $urandom_range(1, 18);
		return 0;
	endfunction

	// push stays high from one transfer into the next unless a gap is wanted.
	task automatic push_triangle(triangle_t t, int gap);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push          <= 1'b1;
		a_x           <= t.a.x;
		a_y           <= t.a.y;
		a_z           <= t.a.z;
		b_x           <= t.b.x;
		b_y           <= t.b.y;
		b_z           <= t.b.z;
		c_x           <= t.c.x;
		c_y           <= t.c.y;
		c_z           <= t.c.z;
		last_triangle <= t.last;
		@(posedge clk);
		while (full)
			@(posedge clk);
		tracker.note_triangle(t);
	endtask

	task automatic play_mesh();
		triangle_t t;
		while (mesh_queue.size() > 0) begin
			t = mesh_queue.pop_front();
			push_triangle(t, producer_gap());
		end
	endtask

	task automatic drain();
		push <= 1'b0;
		while (tracker.expected_volumes.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Upper bits of the query writes carry noise that the block must discard.
	task automatic configure(vertex_t qp, logic [31:0] tol);
		mvpi_pkg::cfg_reg_t order [4];
		logic [31:0]        value [4];
		order = '{mvpi_pkg::REG_QUERY_X, mvpi_pkg::REG_QUERY_Y, mvpi_pkg::REG_QUERY_Z,
		          mvpi_pkg::REG_TOLERANCE};
		value = '{{16'($urandom), 16'(qp.x)}, {16'($urandom), 16'(qp.y)},
		          {16'($urandom), 16'(qp.z)}, tol};
		for (int i = 0; i < 4; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= order[i];
			cfg_data  <= value[i];
			@(posedge clk);
			tracker.set_register(order[i], value[i]);
		end
		cfg_write   <= 1'b0;
		query_point = qp;
	endtask

	initial begin
		volume_result_t got;
		int             stall_left;
		stall_left = 0;
		pop <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				got.reference_six_volume = reference_six_volume;
				got.query_six_volume     = query_six_volume;
				got.inside_res           = inside_res;
				got.overflowed           = overflowed;
				tracker.check_result(got);
			end
			if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if (idling && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 17);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		#100_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		vertex_t     origin, corner, low, high, pivot, far_a, far_b, far_c, qp;
		vertex_t     t0, t1, t2, t3;
		logic [31:0] tol;
		int          target;
		tracker = new();
		idling  = 1'b1;
		arst_n  = 1'b0;
		push          <= 1'b0;
		a_x           <= '0;
		a_y           <= '0;
		a_z           <= '0;
		b_x           <= '0;
		b_y           <= '0;
		b_z           <= '0;
		c_x           <= '0;
		c_y           <= '0;
		c_z           <= '0;
		last_triangle <= 1'b0;
		cfg_write     <= 1'b0;
		cfg_index     <= mvpi_pkg::REG_QUERY_X;
		cfg_data      <= '0;
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		origin = '0;
		low    = '{COORD_MIN, COORD_MIN, COORD_MIN};
		high   = '{COORD_MAX, COORD_MAX, COORD_MAX};
		corner = '{COORD_MAX, COORD_MIN, COORD_MAX};
		t0     = '{coord_t'(-256), coord_t'(-256), coord_t'(-256)};
		t1     = '{coord_t'(768), coord_t'(-256), coord_t'(-256)};
		t2     = '{coord_t'(-256), coord_t'(768), coord_t'(-256)};
		t3     = '{coord_t'(-256), coord_t'(-256), coord_t'(768)};

		// Directed: the origin lies inside this tetrahedron, so both sums must agree.
		configure(origin, 32'd0);
		add_tetra(t0, t1, t2, t3);
		close_mesh();
		play_mesh();
		add_face(low, '{COORD_MAX, COORD_MAX, COORD_MIN}, '{COORD_MIN, COORD_MAX, COORD_MAX});
		close_mesh();
		play_mesh();
		add_face(high, high, high);
		close_mesh();
		play_mesh();
		add_face(origin, '{coord_t'(256), coord_t'(256), coord_t'(256)},
		         '{coord_t'(512), coord_t'(512), coord_t'(512)});
		add_face(low, high, low);
		add_face(high, low, corner);
		close_mesh();
		play_mesh();
		drain();
		configure(corner, 32'hFFFF_FFFF);
		add_face(high, low, corner);
		close_mesh();
		play_mesh();
		add_tetra(t0, t1, t2, t3);
		close_mesh();
		play_mesh();
		drain();
		configure(corner, 32'd0);
		add_tetra(t0, t1, t2, t3);
		close_mesh();
		play_mesh();
		drain();

		// One long mesh of maximal tetrahedra, sent back to back, drives both sums high.
		idling = 1'b0;
		pivot  = '{COORD_MIN, COORD_MAX, COORD_MIN};
		far_a  = high;
		far_b  = '{COORD_MIN, COORD_MIN, COORD_MAX};
		far_c  = '{COORD_MAX, COORD_MIN, COORD_MIN};
		configure(pivot, 32'd0);
		add_face(pivot, far_b, far_c);
		repeat (LONG_TRIANGLES) add_face(far_a, far_b, far_c);
		close_mesh();
		play_mesh();
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			idling = (phase < 5);
			case (phase)
				0: begin
					qp  = low;
					tol = 32'd0;
				end
				1: begin
					qp  = high;
					tol = 32'hFFFF_FFFF;
				end
				default: begin
					qp = ($urandom_range(0, 1) == 0) ? any_vertex() : near_vertex(origin, 2000);
					case ($urandom_range(0, 3))
						0:       tol = 32'd0;
						1:       tol = 32'hFFFF_FFFF;
						2:       tol = $urandom_range(0, 1 << 20);
						default: tol = $urandom;
					endcase
				end
			endcase
			configure(qp, tol);
			target = tracker.triangles + PHASE_ITEMS;
			while (tracker.triangles < target) begin
				build_random_mesh();
				play_mesh();
			end
			drain();
		end

		$display("Sent %0d triangles forming %0d meshes; %0d results compared.",
		         tracker.triangles, tracker.meshes, tracker.checked);
		$display("%0d meshes saturated and %0d judged the query point inside.",
		         tracker.saturated_meshes, tracker.inside_meshes);
		if (tracker.errors == 0 && tracker.expected_volumes.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* sim.f */
sv/mvpi_pkg.sv
sv/mvpi_front.sv
sv/mvpi_queue.sv
sv/mvpi_back.sv
sv/mesh_volume_point_inside.sv
test/testbench.sv
